// ----- sv/rmq_pkg.sv -----
// Package for the rotation matrix to quaternion core.
// Holds payload types, stage widths, saturation constants and sign-extension helpers.
// No dependencies.
package rmq_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned FracBits  = 14;

  // signed radicand width, with headroom for a sum of three elements plus one
  localparam int unsigned RadW    = ((DataWidth > FracBits + 1) ? DataWidth : FracBits + 1) + 3;
  localparam int unsigned RadUW   = RadW - 1;
  localparam int unsigned SqInW   = RadUW + FracBits;
  localparam int unsigned SqRootW = (SqInW + 1) / 2;
  localparam int unsigned SqPadW  = 2 * SqRootW;
  localparam int unsigned SumW    = DataWidth + 2;
  localparam int unsigned MagW    = DataWidth + 1;
  localparam int unsigned NumW    = MagW + FracBits + 1;
  localparam int unsigned DenW    = SqRootW + 1;
  localparam int unsigned QW      = DataWidth - 1;
  localparam int unsigned TopW    = NumW - QW;
  localparam int unsigned CmpW    = (TopW > DenW) ? TopW : DenW;
  localparam int unsigned MainW   = (SqRootW > DataWidth) ? SqRootW : DataWidth;

  localparam logic [DataWidth-1:0] SatHi = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] SatLo = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] OneSat =
      (FracBits >= DataWidth - 1) ? SatHi : (DataWidth'(1) << FracBits);
  localparam logic signed [RadW-1:0] OneRad = RadW'(1) << FracBits;

  // which component comes from the root
  typedef enum logic [1:0] {
    MODE_X = 2'd0,
    MODE_Y = 2'd1,
    MODE_Z = 2'd2,
    MODE_W = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [DataWidth-1:0] m00;
    logic signed [DataWidth-1:0] m01;
    logic signed [DataWidth-1:0] m02;
    logic signed [DataWidth-1:0] m10;
    logic signed [DataWidth-1:0] m11;
    logic signed [DataWidth-1:0] m12;
    logic signed [DataWidth-1:0] m20;
    logic signed [DataWidth-1:0] m21;
    logic signed [DataWidth-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] qx;
    logic signed [DataWidth-1:0] qy;
    logic signed [DataWidth-1:0] qz;
    logic signed [DataWidth-1:0] qw;
    logic                        degenerate;
  } out_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } lane_t;

  typedef struct packed {
    mode_e       mode;
    lane_t [2:0] lane;
  } side_t;

  function automatic logic signed [RadW-1:0] sx_rad(logic [DataWidth-1:0] v);
    return signed'({{(RadW-DataWidth){v[DataWidth-1]}}, v});
  endfunction

  function automatic logic signed [SumW-1:0] sx_sum(logic [DataWidth-1:0] v);
    return signed'({{(SumW-DataWidth){v[DataWidth-1]}}, v});
  endfunction

endpackage

// ----- sv/rotation_matrix_to_quaternion_core.sv -----
// Rotation matrix to unit quaternion, signed Q2.14 fixed point.
// One input item carries the nine matrix elements; one output item carries qx, qy, qz,
// qw and a degenerate flag (identity returned when the root is zero).
// Both channels are valid/ready; an item moves on an edge where both are high.
// Pipeline: 2 front stages, 16 square root stages, 1 divider setup stage, 15 divider
// stages, 1 output register.
// Throughput: one item per cycle while in_ready_o is high; every stage is a single
// pipeline register, and the square root and divider each retire one result bit per stage.
// The whole pipeline advances together; a skid register behind the output register
// absorbs one item when the receiver stalls, and in_ready_o drops only while it is full.
// Reset clears all valid bits; payload registers are not reset.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic               en;
  logic               f_vld, s_vld, d_vld;
  logic [RadUW-1:0]   f_rad;
  side_t              f_side, s_side;
  logic [SqRootW-1:0] s_root;
  out_t               d_res;

  logic out_vld_q, skid_vld_q;
  out_t out_q, skid_q;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (f_vld),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_vld),
    .res_o   (d_res)
  );

  logic out_free;
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (out_free) begin
      out_vld_q <= d_vld;
    end else if (d_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= d_res;
    end else if (d_vld) begin
      skid_q <= d_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_valid_o)
    else $error("skid holds an item while output register is empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_valid_o && !out_ready_i))
    else $error("skid filled without a stalled output");

  a_degen_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.qx == '0 && out_data_o.qy == '0 && out_data_o.qz == '0
       && out_data_o.qw == OneSat))
    else $error("degenerate item is not the identity");

endmodule

// ----- sv/rmq_front.sv -----
// Front end: trace and diagonal compares, then case select, radicand and off-diagonal lanes.
// Two register stages. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  in_t              data_i,
  output logic             valid_o,
  output logic [RadUW-1:0] rad_o,
  output side_t            side_o
);

  logic                   a_vld_q;
  in_t                    a_m_q;
  logic signed [RadW-1:0] a_trace_q;
  logic                   a_lt01_q, a_lt12_q, a_lt02_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_m_q     <= data_i;
      a_trace_q <= sx_rad(data_i.m00) + sx_rad(data_i.m11) + sx_rad(data_i.m22);
      a_lt01_q  <= $signed(data_i.m00) < $signed(data_i.m11);
      a_lt12_q  <= $signed(data_i.m11) < $signed(data_i.m22);
      a_lt02_q  <= $signed(data_i.m00) < $signed(data_i.m22);
    end
  end

  mode_e                   mode;
  logic signed [RadW-1:0]  dii, djj, dkk, rad_s;
  logic signed [SumW-1:0]  n [3];
  side_t                   side_d;
  logic [RadUW-1:0]        rad_d;

  always_comb begin
    if (a_trace_q > 0) begin
      mode = MODE_W;
    end else if (a_lt01_q) begin
      mode = a_lt12_q ? MODE_Z : MODE_Y;
    end else begin
      mode = a_lt02_q ? MODE_Z : MODE_X;
    end

    unique case (mode)
      MODE_X: begin
        dii  = sx_rad(a_m_q.m00);
        djj  = sx_rad(a_m_q.m11);
        dkk  = sx_rad(a_m_q.m22);
        n[0] = sx_sum(a_m_q.m21) - sx_sum(a_m_q.m12);
        n[1] = sx_sum(a_m_q.m10) + sx_sum(a_m_q.m01);
        n[2] = sx_sum(a_m_q.m20) + sx_sum(a_m_q.m02);
      end
      MODE_Y: begin
        dii  = sx_rad(a_m_q.m11);
        djj  = sx_rad(a_m_q.m22);
        dkk  = sx_rad(a_m_q.m00);
        n[0] = sx_sum(a_m_q.m02) - sx_sum(a_m_q.m20);
        n[1] = sx_sum(a_m_q.m21) + sx_sum(a_m_q.m12);
        n[2] = sx_sum(a_m_q.m01) + sx_sum(a_m_q.m10);
      end
      MODE_Z: begin
        dii  = sx_rad(a_m_q.m22);
        djj  = sx_rad(a_m_q.m00);
        dkk  = sx_rad(a_m_q.m11);
        n[0] = sx_sum(a_m_q.m10) - sx_sum(a_m_q.m01);
        n[1] = sx_sum(a_m_q.m02) + sx_sum(a_m_q.m20);
        n[2] = sx_sum(a_m_q.m12) + sx_sum(a_m_q.m21);
      end
      default: begin
        dii  = '0;
        djj  = '0;
        dkk  = '0;
        n[0] = sx_sum(a_m_q.m21) - sx_sum(a_m_q.m12);
        n[1] = sx_sum(a_m_q.m02) - sx_sum(a_m_q.m20);
        n[2] = sx_sum(a_m_q.m10) - sx_sum(a_m_q.m01);
      end
    endcase

    if (mode == MODE_W) begin
      rad_s = a_trace_q + OneRad;
    end else begin
      rad_s = dii - djj - dkk + OneRad;
    end
    rad_d = rad_s[RadW-1] ? '0 : rad_s[RadUW-1:0];

    side_d.mode = mode;
    for (int l = 0; l < 3; l++) begin
      side_d.lane[l].neg = n[l][SumW-1];
      side_d.lane[l].mag = n[l][SumW-1] ? MagW'(-n[l]) : MagW'(n[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_d;
      side_o <= side_d;
    end
  end

endmodule

// ----- sv/rmq_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Carries the lane sideband alongside. Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [RadUW-1:0]   rad_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [SqRootW-1:0] root_o,
  output side_t              side_o
);

  localparam int unsigned RemW = SqRootW + 3;

  logic               vld_q  [SqRootW];
  logic [RemW-1:0]    rem_q  [SqRootW];
  logic [SqRootW-1:0] res_q  [SqRootW];
  logic [SqPadW-1:0]  v_q    [SqRootW];
  side_t              side_q [SqRootW];

  for (genvar s = 0; s < SqRootW; s++) begin : g_step
    logic               vld_in;
    logic [RemW-1:0]    rem_in, rem_sh, trial, rem_d;
    logic [SqRootW-1:0] res_in, res_d;
    logic [SqPadW-1:0]  v_in;
    side_t              side_in;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign res_in  = '0;
      assign v_in    = SqPadW'(rad_i) << FracBits;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign res_in  = res_q[s-1];
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_in[RemW-3:0], v_in[SqPadW-1 -: 2]};
      trial  = {{(RemW-SqRootW-2){1'b0}}, res_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        res_d = {res_in[SqRootW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        res_d = {res_in[SqRootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        res_q[s]  <= res_d;
        v_q[s]    <= v_in << 2;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[SqRootW-1];
  assign root_o  = res_q[SqRootW-1];
  assign side_o  = side_q[SqRootW-1];

endmodule

// ----- sv/rmq_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage, with rounding
// folded into the numerator; final saturation and component routing. Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [SqRootW-1:0] root_i,
  input  side_t              side_i,
  output logic               valid_o,
  output out_t               res_o
);

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [DenW-1:0] rem;
    logic [QW-1:0]   low;
    logic [QW-1:0]   quo;
  } dlane_t;

  typedef struct packed {
    mode_e              mode;
    logic               degen;
    logic [SqRootW-1:0] main;
    logic [DenW-1:0]    den;
    dlane_t [2:0]       lane;
  } dstage_t;

  // prep stage: numerator = mag * 2^F + root, overflow check against den * 2^QW
  dstage_t         prep_d;
  logic [SqRootW:0] main_sum;
  logic [NumW-1:0] num [3];
  logic [TopW-1:0] top [3];

  always_comb begin
    main_sum     = {1'b0, root_i} + (SqRootW+1)'(1);
    prep_d.mode  = side_i.mode;
    prep_d.degen = (root_i == '0);
    prep_d.main  = main_sum[SqRootW:1];
    prep_d.den   = {root_i, 1'b0};
    for (int l = 0; l < 3; l++) begin
      num[l] = (NumW'(side_i.lane[l].mag) << FracBits) + NumW'(root_i);
      top[l] = num[l][NumW-1:QW];
      prep_d.lane[l].neg = side_i.lane[l].neg;
      prep_d.lane[l].ovf = CmpW'(top[l]) >= CmpW'(prep_d.den);
      prep_d.lane[l].rem = DenW'(top[l]);
      prep_d.lane[l].low = num[l][QW-1:0];
      prep_d.lane[l].quo = '0;
    end
  end

  logic    vld_q [QW+1];
  dstage_t st_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= prep_d;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    dstage_t       st_d;
    logic [DenW:0] sh [3];

    always_comb begin
      st_d = st_q[s-1];
      for (int l = 0; l < 3; l++) begin
        sh[l] = {st_q[s-1].lane[l].rem, st_q[s-1].lane[l].low[QW-1]};
        st_d.lane[l].low = st_q[s-1].lane[l].low << 1;
        if (sh[l] >= {1'b0, st_q[s-1].den}) begin
          st_d.lane[l].rem = DenW'(sh[l] - {1'b0, st_q[s-1].den});
          st_d.lane[l].quo = {st_q[s-1].lane[l].quo[QW-2:0], 1'b1};
        end else begin
          st_d.lane[l].rem = sh[l][DenW-1:0];
          st_d.lane[l].quo = {st_q[s-1].lane[l].quo[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d;
      end
    end
  end

  logic [DataWidth-1:0] lv [3];
  logic [DataWidth-1:0] main_sat;
  logic [DataWidth-1:0] c0, c1, c2, c3;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (st_q[QW].lane[l].ovf) begin
        lv[l] = st_q[QW].lane[l].neg ? SatLo : SatHi;
      end else if (st_q[QW].lane[l].neg) begin
        lv[l] = -{1'b0, st_q[QW].lane[l].quo};
      end else begin
        lv[l] = {1'b0, st_q[QW].lane[l].quo};
      end
    end
    main_sat = (MainW'(st_q[QW].main) > MainW'(SatHi)) ? SatHi : DataWidth'(st_q[QW].main);

    unique case (st_q[QW].mode)
      MODE_X: begin
        c0 = main_sat; c1 = lv[1]; c2 = lv[2]; c3 = lv[0];
      end
      MODE_Y: begin
        c0 = lv[2]; c1 = main_sat; c2 = lv[1]; c3 = lv[0];
      end
      MODE_Z: begin
        c0 = lv[1]; c1 = lv[2]; c2 = main_sat; c3 = lv[0];
      end
      default: begin
        c0 = lv[0]; c1 = lv[1]; c2 = lv[2]; c3 = main_sat;
      end
    endcase

    if (st_q[QW].degen) begin
      res_o.qx = '0;
      res_o.qy = '0;
      res_o.qz = '0;
      res_o.qw = OneSat;
    end else begin
      res_o.qx = c0;
      res_o.qy = c1;
      res_o.qz = c2;
      res_o.qw = c3;
    end
    res_o.degenerate = st_q[QW].degen;
  end

  assign valid_o = vld_q[QW];

endmodule

// ----- verif/rotation_matrix_to_quaternion_core_tb.sv -----
// Testbench for rotation_matrix_to_quaternion_core: directed and random matrices,
// predicted in fixed point and checked field by field against the output stream.
// Depends on rmq_pkg and the core RTL.
module rotation_matrix_to_quaternion_core_tb;
  import rmq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_mats[$];
  out_t expected_quats[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_degen = 0;
  int   cyc = 0;
  bit   stim_done = 1'b0;
  bit   in_taken = 1'b0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_by_root(longint n, longint unsigned s);
    longint unsigned mag, den, q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    den = s * 2;
    q = ((mag << FracBits) + (den >> 1)) / den;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [DataWidth-1:0] clip(longint v);
    longint hi, lo;
    hi = (longint'(1) << (DataWidth - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[DataWidth-1:0];
    if (v < lo) return lo[DataWidth-1:0];
    return v[DataWidth-1:0];
  endfunction

  function automatic out_t predict_quat(in_t a);
    longint m[3][3];
    longint q[4];
    longint one, tr, rad;
    longint unsigned s;
    int i, j, k;
    bit dg;
    out_t o;
    one = longint'(1) << FracBits;
    m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
    m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
    m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
    dg = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rad = tr + one;
      s = int_sqrt(longint'(rad) << FracBits);
      if (s == 0) dg = 1'b1;
      else begin
        q[MODE_W] = longint'((s + 1) >> 1);
        q[MODE_X] = div_by_root(m[2][1] - m[1][2], s);
        q[MODE_Y] = div_by_root(m[0][2] - m[2][0], s);
        q[MODE_Z] = div_by_root(m[1][0] - m[0][1], s);
      end
    end else begin
      if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
      else i = (m[0][0] < m[2][2]) ? 2 : 0;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + one;
      if (rad < 0) rad = 0;
      s = int_sqrt(longint'(rad) << FracBits);
      if (s == 0) dg = 1'b1;
      else begin
        q[i] = longint'((s + 1) >> 1);
        q[MODE_W] = div_by_root(m[k][j] - m[j][k], s);
        q[j] = div_by_root(m[j][i] + m[i][j], s);
        q[k] = div_by_root(m[k][i] + m[i][k], s);
      end
    end
    if (dg) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = one;
    end
    o.qx = clip(q[0]);
    o.qy = clip(q[1]);
    o.qz = clip(q[2]);
    o.qw = clip(q[3]);
    o.degenerate = dg;
    return o;
  endfunction

  function automatic in_t diag_mat(int d0, int d1, int d2);
    in_t a;
    a = '0;
    a.m00 = d0[DataWidth-1:0];
    a.m11 = d1[DataWidth-1:0];
    a.m22 = d2[DataWidth-1:0];
    return a;
  endfunction

  // random matrix: raw random bits, or a rotation with orthonormal axes scaled near 1.0, some with noise
  function automatic in_t rand_mat();
    in_t a;
    real ax, ay, az, n, th, c, s, t;
    real r[9];
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      a = in_t'((9*DataWidth)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      return a;
    end
    ax = real'($urandom_range(0, 2000)) - 1000.0;
    ay = real'($urandom_range(0, 2000)) - 1000.0;
    az = real'($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(ax * ax + ay * ay + az * az);
    if (n < 1.0) begin
      ax = 1.0; n = 1.0;
    end
    ax /= n; ay /= n; az /= n;
    th = real'($urandom_range(0, 62832)) / 10000.0;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    r[0] = t*ax*ax + c;    r[1] = t*ax*ay - s*az; r[2] = t*ax*az + s*ay;
    r[3] = t*ax*ay + s*az; r[4] = t*ay*ay + c;    r[5] = t*ay*az - s*ax;
    r[6] = t*ax*az - s*ay; r[7] = t*ay*az + s*ax; r[8] = t*az*az + c;
    for (int e = 0; e < 9; e++) begin
      int v;
      v = int'(r[e] * 16384.0) + ((sel == 9) ? $urandom_range(0, 600) - 300 : 0);
      a[(8 - e) * DataWidth +: DataWidth] = v[DataWidth-1:0];
    end
    return a;
  endfunction

  initial begin
    in_t a;
    // identity, each axis dominant, ties, extremes
    pending_mats.push_back(diag_mat(16384, 16384, 16384));
    pending_mats.push_back(diag_mat(16384, -16384, -16384));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384));
    pending_mats.push_back(diag_mat(0, 0, 0));
    pending_mats.push_back(diag_mat(-5000, -5000, -5000));
    pending_mats.push_back(diag_mat(-16384, -16384, -16384));
    pending_mats.push_back(diag_mat(-32768, 32767, 32767));
    pending_mats.push_back(diag_mat(32767, 32767, 32767));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768));
    pending_mats.push_back(diag_mat(1, 0, 0));
    pending_mats.push_back(diag_mat(-8192, -8192, 0));
    pending_mats.push_back(diag_mat(-16383, 1, 1));
    a = '1;
    pending_mats.push_back(a);
    a = '0;
    a.m01 = 16'sh7fff; a.m10 = 16'sh8000; a.m02 = 16'sh8000;
    a.m20 = 16'sh7fff; a.m12 = 16'sh7fff; a.m21 = 16'sh8000; a.m00 = 1;
    pending_mats.push_back(a);
    a.m00 = 16'sh8000; a.m11 = 16'sh7fff; a.m22 = 16'sh8000;
    pending_mats.push_back(a);
    a = {9{16'sh7fff}};
    pending_mats.push_back(a);
    a = {9{16'sh8000}};
    pending_mats.push_back(a);
    a = diag_mat(-32768, -32768, 32767);
    a.m01 = 16'sh7fff; a.m10 = 16'sh7fff; a.m12 = 16'sh8000; a.m21 = 16'sh8000;
    pending_mats.push_back(a);
    for (int n = 0; n < 850; n++) pending_mats.push_back(rand_mat());
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // input handshake as seen at the rising edge
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_valid) expected_quats.push_back(predict_quat(in_data));
        if (pending_mats.size() > 0 &&
            ((cyc > 500 && cyc < 800) || $urandom_range(0, 99) >= 29)) begin
          in_data <= pending_mats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (pending_mats.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver: long hold-off early on, no stalls in a later window
  always @(negedge clk) begin
    if (cyc >= 300 && cyc < 450) out_ready <= 1'b0;
    else if (cyc > 500 && cyc < 800) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 29);
  end

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        $error("output item with nothing expected");
        n_errors++;
      end else begin
        e = expected_quats.pop_front();
        n_checked++;
        if (e.degenerate) n_degen++;
        if (out_data.qx !== e.qx) begin
          $error("qx expected %0d actual %0d", e.qx, out_data.qx); n_errors++;
        end
        if (out_data.qy !== e.qy) begin
          $error("qy expected %0d actual %0d", e.qy, out_data.qy); n_errors++;
        end
        if (out_data.qz !== e.qz) begin
          $error("qz expected %0d actual %0d", e.qz, out_data.qz); n_errors++;
        end
        if (out_data.qw !== e.qw) begin
          $error("qw expected %0d actual %0d", e.qw, out_data.qw); n_errors++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate expected %0d actual %0d", e.degenerate, out_data.degenerate);
          n_errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_quats.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d quaternions (%0d degenerate) through stalls and backpressure",
             n_checked, n_degen);
    if (n_errors == 0) $display("rotation_matrix_to_quaternion_core_tb: done, clean");
    else $display("rotation_matrix_to_quaternion_core_tb: done, errors");
    $finish;
  end

  initial begin
    #500000;
    $display("timeout");
    $display("rotation_matrix_to_quaternion_core_tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_core.sv
verif/rotation_matrix_to_quaternion_core_tb.sv
